// ===== sv/stmc_pkg.sv =====
`timescale 1ns / 1ps

package stmc_pkg;

  // Widths of the register, coordinate and index values
  localparam int AXIS_W   = 11;
  localparam int COORD_W  = 10;
  localparam int INDEX_W  = 31;
  localparam int ROWSUM_W = 2 * AXIS_W;
  localparam int ACT_W    = 3;
  localparam int STEP_W   = 3;

  // Largest point count per axis; the widths above are sized for it
  localparam int MAX_AXIS_POINTS = 1024;

  // Defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEF     = 8;

  // Register reset values
  localparam logic [AXIS_W-1:0] POINTS_X_RST = 11'd5;
  localparam logic [AXIS_W-1:0] POINTS_Y_RST = 11'd4;
  localparam logic [AXIS_W-1:0] POINTS_Z_RST = 11'd3;
  localparam logic [AXIS_W-1:0] POINTS_MIN   = 11'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_POINTS_X = 2'd0;
  localparam logic [1:0] REG_POINTS_Y = 2'd1;
  localparam logic [1:0] REG_POINTS_Z = 2'd2;

  // Request actions
  localparam logic [ACT_W-1:0] ACT_VOLUME  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_XMIN    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_YMIN    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ZMIN    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_XMAX    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_YMAX    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_ZMAX    = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 3'd7;

  // Final beat of each kind of request
  localparam logic [STEP_W-1:0] VOL_LAST_STEP  = 3'd5;
  localparam logic [STEP_W-1:0] FACE_LAST_STEP = 3'd1;

  // Corner offset codes: bit 2 = +1 column, bit 1 = +1 row, bit 0 = +1 layer
  localparam logic [2:0] V000 = 3'b000;
  localparam logic [2:0] V001 = 3'b001;
  localparam logic [2:0] V010 = 3'b010;
  localparam logic [2:0] V011 = 3'b011;
  localparam logic [2:0] V100 = 3'b100;
  localparam logic [2:0] V101 = 3'b101;
  localparam logic [2:0] V110 = 3'b110;
  localparam logic [2:0] V111 = 3'b111;

  // One classified request on its way from the front end to the back end
  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic               bad;
    logic [INDEX_W-1:0] base;
  } stmc_entry_t;

  // Corner codes {a, b, c, d} of one beat, a in the top three bits.
  // For triangles the d code is unused.
  function automatic logic [11:0] corner_codes(input logic [ACT_W-1:0] act,
                                               input logic [STEP_W-1:0] step);
    logic [11:0] codes;
    codes = {V000, V000, V000, V000};
    case (act)
      ACT_VOLUME: begin
        case (step)
          3'd0:    codes = {V000, V001, V100, V110};
          3'd1:    codes = {V001, V000, V010, V110};
          3'd2:    codes = {V011, V001, V010, V110};
          3'd3:    codes = {V001, V011, V111, V110};
          3'd4:    codes = {V101, V001, V111, V110};
          default: codes = {V001, V101, V100, V110};
        endcase
      end
      ACT_XMIN: codes = step[0] ? {V011, V001, V010, V000} : {V001, V000, V010, V000};
      ACT_XMAX: codes = step[0] ? {V001, V011, V010, V000} : {V000, V001, V010, V000};
      ACT_YMIN: codes = step[0] ? {V001, V101, V100, V000} : {V000, V001, V100, V000};
      ACT_YMAX: codes = step[0] ? {V101, V001, V100, V000} : {V001, V000, V100, V000};
      ACT_ZMIN: codes = step[0] ? {V010, V000, V110, V000} : {V000, V100, V110, V000};
      ACT_ZMAX: codes = step[0] ? {V000, V010, V110, V000} : {V100, V000, V110, V000};
      default:  codes = {V000, V000, V000, V000};
    endcase
    return codes;
  endfunction

endpackage

// ===== sv/structured_tet_mesh_connectivity.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// in_       slave      tuser: action; tdata: col, row, layer
// out_      master     tdata: corner_a..corner_d; tuser: label, bad; tlast: last
// cfg_      slave      cfg_index selects points_x, points_y or points_z; cfg_data
//
// A volume cell yields six beats, one per cycle while the output is not stalled;
// a face cell yields two beats and a rejected request one.
// After a request is accepted, three front stages build the base index, the
// queue entry is written, then the output register loads the first beat.
// Reset restores points_x/y/z to 5, 4 and 3 and empties the pipeline and queue.
// Requests are taken while fewer than QDEPTH are in flight; output stalls back up
// into the queue without stopping the input until that limit is reached.

module structured_tet_mesh_connectivity
  import stmc_pkg::*;
#(
  parameter int QDEPTH          = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input request channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2:0]          in_tuser,   // [2:0] action
  input  logic [31:0]         in_tdata,   // [9:0] col, [19:10] row, [29:20] layer
  // Result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [127:0]        out_tdata,  // [30:0] a, [61:31] b, [92:62] c, [123:93] d
  output logic [3:0]          out_tuser,  // [2:0] label, [3] bad
  output logic                out_tlast,
  // Configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [AXIS_W-1:0]   cfg_data
);

  localparam int USED_W = $clog2(QDEPTH + 1);

  logic [AXIS_W-1:0] points_x_r, points_y_r, points_z_r;
  logic [AXIS_W-1:0] cfg_clamped;
  logic [USED_W-1:0] used_r, used_nxt;
  logic              in_accept;
  logic              push;
  stmc_entry_t       push_entry;
  logic              pop;
  logic              head_valid;
  stmc_entry_t       head;
  logic              q_full;

  // Configuration registers, clamped to the legal point counts
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < POINTS_MIN) begin
      cfg_clamped = POINTS_MIN;
    end else if (32'(cfg_data) > MAX_AXIS_POINTS) begin
      cfg_clamped = AXIS_W'(MAX_AXIS_POINTS);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_x_r <= POINTS_X_RST;
      points_y_r <= POINTS_Y_RST;
      points_z_r <= POINTS_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POINTS_X: points_x_r <= cfg_clamped;
        REG_POINTS_Y: points_y_r <= cfg_clamped;
        REG_POINTS_Z: points_z_r <= cfg_clamped;
        default:      points_x_r <= points_x_r;
      endcase
    end
  end

  // Requests in flight between intake and the last beat; bounds the queue
  assign in_tready = (used_r < USED_W'(QDEPTH));
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    used_nxt = used_r;
    if (in_accept && !pop) begin
      used_nxt = used_r + 1'b1;
    end else if (pop && !in_accept) begin
      used_nxt = used_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  stmc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .act        (in_tuser),
    .col        (in_tdata[9:0]),
    .row        (in_tdata[19:10]),
    .layer      (in_tdata[29:20]),
    .points_x   (points_x_r),
    .points_y   (points_y_r),
    .points_z   (points_z_r),
    .push       (push),
    .push_entry (push_entry)
  );

  stmc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  stmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .points_x   (points_x_r),
    .points_z   (points_z_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_user   (out_tuser),
    .out_last   (out_tlast)
  );

  // The in-flight count never passes the queue depth
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(QDEPTH))
    else $error("in-flight request count exceeds queue depth");

  // The front pipeline never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full && !pop))
    else $error("push into a full queue");

  // A rejected request is a single beat with all corners zero
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (out_tlast && (out_tdata == '0)))
    else $error("rejected request beat malformed");

  // The back end only retires a request that is present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (head_valid && (used_r != '0)))
    else $error("retire without a queued request");

endmodule

// ===== sv/stmc_front.sv =====
`timescale 1ns / 1ps

module stmc_front
  import stmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [ACT_W-1:0]    act,
  input  logic [COORD_W-1:0]  col,
  input  logic [COORD_W-1:0]  row,
  input  logic [COORD_W-1:0]  layer,
  input  logic [AXIS_W-1:0]   points_x,
  input  logic [AXIS_W-1:0]   points_y,
  input  logic [AXIS_W-1:0]   points_z,
  output logic                push,
  output stmc_entry_t         push_entry
);

  logic [AXIS_W-1:0] px_m1;
  logic [AXIS_W-1:0] py_m1;
  logic [AXIS_W-1:0] pz_m1;
  logic              use_c;
  logic              use_r;
  logic              use_l;
  logic              bad;
  logic [AXIS_W-1:0] cc;
  logic [AXIS_W-1:0] rr;
  logic [AXIS_W-1:0] ll;

  logic              v0_r, v1_r, v2_r;
  logic [ACT_W-1:0]  act0_r, act1_r, act2_r;
  logic              bad0_r, bad1_r, bad2_r;
  logic [AXIS_W-1:0] cc0_r, cc1_r;
  logic [AXIS_W-1:0] rr0_r;
  logic [AXIS_W-1:0] ll0_r, ll1_r, ll2_r;
  logic [ROWSUM_W-1:0] m1_r;
  logic [INDEX_W-1:0]  m2_r;

  logic [ROWSUM_W:0]   rowsum;
  logic [33:0]         prod2;
  logic [ROWSUM_W-1:0] prod1;

  // Classify the request: pick the plane coordinate and check the bounds
  assign px_m1 = points_x - 11'd1;
  assign py_m1 = points_y - 11'd1;
  assign pz_m1 = points_z - 11'd1;
  assign use_c = !(act == ACT_XMIN || act == ACT_XMAX);
  assign use_r = !(act == ACT_YMIN || act == ACT_YMAX);
  assign use_l = !(act == ACT_ZMIN || act == ACT_ZMAX);

  assign bad = (act == ACT_UNKNOWN)
            || (use_c && ({1'b0, col} >= px_m1))
            || (use_r && ({1'b0, row} >= py_m1))
            || (use_l && ({1'b0, layer} >= pz_m1));

  always_comb begin
    cc = {1'b0, col};
    rr = {1'b0, row};
    ll = {1'b0, layer};
    case (act)
      ACT_XMIN: cc = '0;
      ACT_XMAX: cc = px_m1;
      ACT_YMIN: rr = '0;
      ACT_YMAX: rr = py_m1;
      ACT_ZMIN: ll = '0;
      ACT_ZMAX: ll = pz_m1;
      default:  cc = {1'b0, col};
    endcase
  end

  // Stage arithmetic: row times points_x, then (row term + column) times points_z
  assign prod1  = {11'b0, rr0_r} * {11'b0, points_x};
  assign rowsum = {1'b0, m1_r} + {12'b0, cc1_r};
  assign prod2  = {11'b0, rowsum} * {23'b0, points_z};

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    act0_r <= act;
    bad0_r <= bad;
    cc0_r  <= cc;
    rr0_r  <= rr;
    ll0_r  <= ll;

    act1_r <= act0_r;
    bad1_r <= bad0_r;
    cc1_r  <= cc0_r;
    ll1_r  <= ll0_r;
    m1_r   <= prod1;

    act2_r <= act1_r;
    bad2_r <= bad1_r;
    ll2_r  <= ll1_r;
    m2_r   <= prod2[INDEX_W-1:0];
  end

  // Finish the 1-based base index and hand the request to the queue
  assign push            = v2_r;
  assign push_entry.act  = act2_r;
  assign push_entry.bad  = bad2_r;
  assign push_entry.base = m2_r + {20'b0, ll2_r} + 31'd1;

endmodule

// ===== sv/stmc_queue.sv =====
`timescale 1ns / 1ps

module stmc_queue
  import stmc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  stmc_entry_t push_entry,
  input  logic        pop,
  output logic        head_valid,
  output stmc_entry_t head,
  output logic        full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  stmc_entry_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head       = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== sv/stmc_back.sv =====
`timescale 1ns / 1ps

module stmc_back
  import stmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [AXIS_W-1:0]   points_x,
  input  logic [AXIS_W-1:0]   points_z,
  input  logic                head_valid,
  input  stmc_entry_t         head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [127:0]        out_data,
  output logic [3:0]          out_user,
  output logic                out_last
);

  logic [ROWSUM_W-1:0] rs_r;
  logic [ROWSUM_W-1:0] rs_prod;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [127:0]        out_data_r;
  logic [3:0]          out_user_r;
  logic                out_last_r;

  logic                load;
  logic                is_last;
  logic [11:0]         codes;
  logic [INDEX_W-1:0]  corner [4];
  logic [ACT_W-1:0]    label;

  // Row stride points_x * points_z; the user must change the registers only while idle (not enforced here)
  assign rs_prod = {11'b0, points_x} * {11'b0, points_z};

  always_ff @(posedge clk) begin
    rs_r <= rs_prod;
  end

  // A beat is built whenever a request is queued and the output register is free or being drained
  assign load = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    if (head.bad) begin
      is_last = 1'b1;
    end else if (head.act == ACT_VOLUME) begin
      is_last = (step_r == VOL_LAST_STEP);
    end else begin
      is_last = (step_r == FACE_LAST_STEP);
    end
  end

  assign pop = load && is_last;

  // Corner indices: base plus the row, column and layer offsets of each code
  assign codes = corner_codes(head.act, step_r);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      corner[k] = head.base
                + (codes[11 - 3*k - 1] ? {9'b0, rs_r} : '0)
                + (codes[11 - 3*k] ? {20'b0, points_z} : '0)
                + {30'b0, codes[11 - 3*k - 2]};
    end
  end

  assign label = (head.act == ACT_UNKNOWN) ? ACT_VOLUME : head.act;

  // Step counter and output valid
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      step_nxt      = is_last ? '0 : step_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      if (head.bad) begin
        out_data_r <= '0;
      end else if (head.act == ACT_VOLUME) begin
        out_data_r <= {4'b0, corner[3], corner[2], corner[1], corner[0]};
      end else begin
        out_data_r <= {4'b0, 31'd0, corner[2], corner[1], corner[0]};
      end
      out_user_r <= {head.bad, label};
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;
  assign out_last  = out_last_r;

endmodule

// ===== test/structured_tet_mesh_connectivity_tb.sv =====
`timescale 1ns / 1ps

module structured_tet_mesh_connectivity_tb;
  import stmc_pkg::*;

  // Index that selects no register; a write there must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [ACT_W-1:0]   act;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] layer;
  } cell_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] a;
    logic [INDEX_W-1:0] b;
    logic [INDEX_W-1:0] c;
    logic [INDEX_W-1:0] d;
    logic [2:0]         label;
    logic               bad;
    logic               last;
  } mesh_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [2:0]          in_tuser = '0;   // [2:0] action
  logic [31:0]         in_tdata = '0;   // [9:0] col, [19:10] row, [29:20] layer
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [127:0]        out_tdata;       // [30:0] a, [61:31] b, [92:62] c, [123:93] d
  logic [3:0]          out_tuser;       // [2:0] label, [3] bad
  logic                out_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [AXIS_W-1:0]   cfg_data = '0;

  // Grid size as the block should hold it.
  longint grid_x = POINTS_X_RST;
  longint grid_y = POINTS_Y_RST;
  longint grid_z = POINTS_Z_RST;

  cell_req_t  cells_pending[$];
  mesh_beat_t beats_due[$];
  int         mismatch_count = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         hold_left = 0;
  logic       hold_go = 1'b0;
  logic       hold_armed = 1'b0;
  logic       quiet = 1'b0;

  structured_tet_mesh_connectivity dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Out-of-range sizes saturate at the legal limits.
  function automatic longint clamp_axis(input logic [AXIS_W-1:0] val);
    if (val < POINTS_MIN) return POINTS_MIN;
    if (val > MAX_AXIS_POINTS) return MAX_AXIS_POINTS;
    return val;
  endfunction

  // One-based vertex number, z varying fastest.
  function automatic logic [INDEX_W-1:0] vertex_at(input longint c, input longint r,
                                                   input longint l);
    longint v;
    v = (r * grid_x + c) * grid_z + l + 1;
    return v[INDEX_W-1:0];
  endfunction

  function automatic void push_beat(input logic [INDEX_W-1:0] a, input logic [INDEX_W-1:0] b,
                                    input logic [INDEX_W-1:0] c, input logic [INDEX_W-1:0] d,
                                    input logic [2:0] label, input logic bad,
                                    input logic last);
    mesh_beat_t bt;
    bt.a = a;
    bt.b = b;
    bt.c = c;
    bt.d = d;
    bt.label = label;
    bt.bad = bad;
    bt.last = last;
    beats_due.push_back(bt);
  endfunction

  // Expected beats for one accepted cell request.
  function automatic void predict_cell_beats(input cell_req_t req);
    longint c, r, l, plane;
    logic use_c, use_r, use_l;
    logic [INDEX_W-1:0] v000, v001, v010, v011, v100, v101, v110, v111;
    logic [INDEX_W-1:0] p, q, s, t;
    c = req.col;
    r = req.row;
    l = req.layer;
    use_c = !(req.act == ACT_XMIN || req.act == ACT_XMAX);
    use_r = !(req.act == ACT_YMIN || req.act == ACT_YMAX);
    use_l = !(req.act == ACT_ZMIN || req.act == ACT_ZMAX);
    if (req.act == ACT_UNKNOWN) begin
      push_beat('0, '0, '0, '0, ACT_VOLUME, 1'b1, 1'b1);
      return;
    end
    if ((use_c && c >= grid_x - 1) || (use_r && r >= grid_y - 1) ||
        (use_l && l >= grid_z - 1)) begin
      push_beat('0, '0, '0, '0, req.act, 1'b1, 1'b1);
      return;
    end
    case (req.act)
      ACT_VOLUME: begin
        v000 = vertex_at(c, r, l);
        v001 = v000 + 1'b1;
        v100 = vertex_at(c + 1, r, l);
        v101 = v100 + 1'b1;
        v010 = vertex_at(c, r + 1, l);
        v011 = v010 + 1'b1;
        v110 = vertex_at(c + 1, r + 1, l);
        v111 = v110 + 1'b1;
        push_beat(v000, v001, v100, v110, ACT_VOLUME, 1'b0, 1'b0);
        push_beat(v001, v000, v010, v110, ACT_VOLUME, 1'b0, 1'b0);
        push_beat(v011, v001, v010, v110, ACT_VOLUME, 1'b0, 1'b0);
        push_beat(v001, v011, v111, v110, ACT_VOLUME, 1'b0, 1'b0);
        push_beat(v101, v001, v111, v110, ACT_VOLUME, 1'b0, 1'b0);
        push_beat(v001, v101, v100, v110, ACT_VOLUME, 1'b0, 1'b1);
      end
      ACT_XMIN, ACT_XMAX: begin
        plane = (req.act == ACT_XMIN) ? 0 : grid_x - 1;
        p = vertex_at(plane, r, l);
        q = p + 1'b1;
        s = vertex_at(plane, r + 1, l);
        t = s + 1'b1;
        if (req.act == ACT_XMIN) begin
          push_beat(q, p, s, '0, req.act, 1'b0, 1'b0);
          push_beat(t, q, s, '0, req.act, 1'b0, 1'b1);
        end else begin
          push_beat(p, q, s, '0, req.act, 1'b0, 1'b0);
          push_beat(q, t, s, '0, req.act, 1'b0, 1'b1);
        end
      end
      ACT_YMIN, ACT_YMAX: begin
        plane = (req.act == ACT_YMIN) ? 0 : grid_y - 1;
        p = vertex_at(c, plane, l);
        q = p + 1'b1;
        s = vertex_at(c + 1, plane, l);
        t = s + 1'b1;
        if (req.act == ACT_YMIN) begin
          push_beat(p, q, s, '0, req.act, 1'b0, 1'b0);
          push_beat(q, t, s, '0, req.act, 1'b0, 1'b1);
        end else begin
          push_beat(q, p, s, '0, req.act, 1'b0, 1'b0);
          push_beat(t, q, s, '0, req.act, 1'b0, 1'b1);
        end
      end
      default: begin
        plane = (req.act == ACT_ZMIN) ? 0 : grid_z - 1;
        p = vertex_at(c, r, plane);
        q = vertex_at(c, r + 1, plane);
        s = vertex_at(c + 1, r, plane);
        t = vertex_at(c + 1, r + 1, plane);
        if (req.act == ACT_ZMIN) begin
          push_beat(p, s, t, '0, req.act, 1'b0, 1'b0);
          push_beat(q, p, t, '0, req.act, 1'b0, 1'b1);
        end else begin
          push_beat(s, p, t, '0, req.act, 1'b0, 1'b0);
          push_beat(p, q, t, '0, req.act, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic string beat_text(input mesh_beat_t bt);
    return $sformatf("a=%0d b=%0d c=%0d d=%0d label=%0d bad=%0b last=%0b",
                     bt.a, bt.b, bt.c, bt.d, bt.label, bt.bad, bt.last);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic cell_req_t make_cell(input logic [ACT_W-1:0] act,
                                          input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row,
                                          input logic [COORD_W-1:0] layer);
    cell_req_t req;
    req.act = act;
    req.col = col;
    req.row = row;
    req.layer = layer;
    return req;
  endfunction

  // A coordinate that is mostly inside the grid, sometimes anywhere in its field.
  function automatic logic [COORD_W-1:0] pick_coord(input longint points);
    if ($urandom_range(0, 99) < 88) return COORD_W'($urandom_range(0, int'(points) - 2));
    return COORD_W'($urandom);
  endfunction

  function automatic cell_req_t random_cell();
    cell_req_t req;
    if ($urandom_range(0, 99) < 4) req.act = ACT_UNKNOWN;
    else req.act = ACT_W'($urandom_range(ACT_VOLUME, ACT_ZMAX));
    req.col = pick_coord(grid_x);
    req.row = pick_coord(grid_y);
    req.layer = pick_coord(grid_z);
    // Coordinates on the face normal are ignored, so they take any value.
    if (req.act == ACT_XMIN || req.act == ACT_XMAX) req.col = COORD_W'($urandom);
    if (req.act == ACT_YMIN || req.act == ACT_YMAX) req.row = COORD_W'($urandom);
    if (req.act == ACT_ZMIN || req.act == ACT_ZMAX) req.layer = COORD_W'($urandom);
    return req;
  endfunction

  // Register write on the configuration channel, only while the block is idle.
  task automatic write_axis(input logic [1:0] idx, input logic [AXIS_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_POINTS_X: grid_x = clamp_axis(val);
      REG_POINTS_Y: grid_y = clamp_axis(val);
      REG_POINTS_Z: grid_z = clamp_axis(val);
      default: ;
    endcase
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) cells_pending.push_back(random_cell());
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (cells_pending.size() != 0 || beats_due.size() != 0);
  endtask

  // Driver: offers the oldest pending cell and predicts its beats on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_cell_beats(cells_pending[0]);
        void'(cells_pending.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // Hold the beat until it is taken.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (cells_pending.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 2);
        in_tvalid <= 1'b0;
      end else if (cells_pending.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= cells_pending[0].act;
        in_tdata <= {2'b00, cells_pending[0].layer, cells_pending[0].row,
                     cells_pending[0].col};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_armed <= 1'b0;
    end else if (hold_go && !hold_armed) begin
      hold_left <= HOLD_CYCLES;
      hold_armed <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    mesh_beat_t seen;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.a = out_tdata[30:0];
        seen.b = out_tdata[61:31];
        seen.c = out_tdata[92:62];
        seen.d = out_tdata[123:93];
        seen.label = out_tuser[2:0];
        seen.bad = out_tuser[3];
        seen.last = out_tlast;
        if (beats_due.size() == 0) begin
          note_mismatch({"unexpected beat: ", beat_text(seen)});
        end else begin
          if (seen !== beats_due[0])
            note_mismatch({"expected ", beat_text(beats_due[0]), " got ", beat_text(seen)});
          void'(beats_due.pop_front());
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus sequence, one grid setting per phase.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset grid 5 x 4 x 3: corners, faces, rejects and the unknown action.
    cells_pending.push_back(make_cell(ACT_VOLUME, 0, 0, 0));
    cells_pending.push_back(make_cell(ACT_VOLUME, 3, 2, 1));
    cells_pending.push_back(make_cell(ACT_VOLUME, 4, 0, 0));
    cells_pending.push_back(make_cell(ACT_VOLUME, 0, 3, 0));
    cells_pending.push_back(make_cell(ACT_VOLUME, 0, 0, 2));
    cells_pending.push_back(make_cell(ACT_XMIN, 1023, 2, 1));
    cells_pending.push_back(make_cell(ACT_YMIN, 3, 1023, 0));
    cells_pending.push_back(make_cell(ACT_ZMIN, 1, 2, 1023));
    cells_pending.push_back(make_cell(ACT_XMAX, 0, 0, 0));
    cells_pending.push_back(make_cell(ACT_YMAX, 3, 1, 1));
    cells_pending.push_back(make_cell(ACT_ZMAX, 2, 0, 0));
    cells_pending.push_back(make_cell(ACT_XMIN, 0, 3, 0));
    cells_pending.push_back(make_cell(ACT_YMAX, 0, 0, 2));
    cells_pending.push_back(make_cell(ACT_ZMAX, 4, 0, 0));
    cells_pending.push_back(make_cell(ACT_UNKNOWN, 0, 0, 0));
    cells_pending.push_back(make_cell(ACT_UNKNOWN, 1023, 1023, 1023));
    cells_pending.push_back(make_cell(ACT_VOLUME, 1023, 1023, 1023));
    queue_random(50);
    wait_drained();

    // Smallest grid, reached through values at and below the minimum.
    write_axis(REG_POINTS_X, 0);
    write_axis(REG_POINTS_Y, 1);
    write_axis(REG_POINTS_Z, 2);
    queue_random(40);
    wait_drained();

    // Largest grid, reached through values at and above the maximum.
    write_axis(REG_POINTS_X, 1024);
    write_axis(REG_POINTS_Y, 2047);
    write_axis(REG_POINTS_Z, 1025);
    cells_pending.push_back(make_cell(ACT_VOLUME, 1022, 1022, 1022));
    cells_pending.push_back(make_cell(ACT_XMAX, 0, 1022, 1022));
    cells_pending.push_back(make_cell(ACT_YMAX, 1022, 0, 1022));
    cells_pending.push_back(make_cell(ACT_ZMAX, 1022, 1022, 0));
    cells_pending.push_back(make_cell(ACT_VOLUME, 1023, 0, 0));
    queue_random(120);
    wait_drained();

    // Small random grid; the receiver stalls long enough to back up the input.
    write_axis(REG_POINTS_X, AXIS_W'($urandom_range(2, 40)));
    write_axis(REG_POINTS_Y, AXIS_W'($urandom_range(2, 40)));
    write_axis(REG_POINTS_Z, AXIS_W'($urandom_range(2, 40)));
    write_axis(REG_UNUSED, AXIS_W'($urandom));
    queue_random(100);
    @(posedge clk);
    hold_go <= 1'b1;
    wait_drained();

    // Lopsided grid: random width in x, flat in y, wide in z.
    write_axis(REG_POINTS_X, AXIS_W'($urandom_range(0, 2047)));
    write_axis(REG_POINTS_Y, 3);
    write_axis(REG_POINTS_Z, AXIS_W'($urandom_range(500, 1024)));
    queue_random(100);
    wait_drained();

    // Final stretch at full rate on both sides.
    write_axis(REG_POINTS_X, AXIS_W'($urandom_range(2, 16)));
    write_axis(REG_POINTS_Y, AXIS_W'($urandom_range(2, 16)));
    write_axis(REG_POINTS_Z, AXIS_W'($urandom_range(2, 16)));
    @(posedge clk);
    quiet <= 1'b1;
    queue_random(80);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
